// ----- src/hkt_pkg.sv -----
`timescale 1ns / 1ps

package hkt_pkg;

  // Default sizes of the table.
  localparam int DEF_SLOTS      = 1024;
  localparam int DEF_HOP_WINDOW = 32;
  localparam int DEF_ADD_WINDOW = 256;

  // Fixed field widths.
  localparam int KEY_W    = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 11;
  localparam int CNT_W    = 11;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_ZERO      = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_HOP,
    ST_MV1,
    ST_MV2,
    ST_FIN
  } state_t;

endpackage

// ----- src/hkt_ram.sv -----
`timescale 1ns / 1ps

module hkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hopscotch_int_key_table.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// input     in_mode, in_key                         beat taken when start & !busy
// result    out_status, out_position,
//           out_entry_count                         beat shown while out_strobe is high
//
// A zero key or an unused mode is answered from idle without a table scan. Lookup
// and remove walk up to HOP_WINDOW slots, one memory read per cycle. Insert walks
// up to ADD_WINDOW slots, then each relocation round reads up to HOP_WINDOW - 1
// slots and writes twice, the moved key into the free slot and then zero into the
// vacated slot; all reads go through the single read port of the slot memory.
// After reset a clearing pass writes every slot, with busy high throughout.
// The receiver cannot stall; each result beat is shown for exactly one cycle.

module hopscotch_int_key_table #(
  parameter int SLOTS      = hkt_pkg::DEF_SLOTS,
  parameter int HOP_WINDOW = hkt_pkg::DEF_HOP_WINDOW,
  parameter int ADD_WINDOW = hkt_pkg::DEF_ADD_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hkt_pkg::MODE_W-1:0]      in_mode,
  input  logic signed [hkt_pkg::KEY_W-1:0] in_key,
  output logic                            out_strobe,
  output logic [hkt_pkg::STATUS_W-1:0]    out_status,
  output logic [hkt_pkg::POS_W-1:0]       out_position,
  output logic [hkt_pkg::CNT_W-1:0]       out_entry_count
);

  import hkt_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int DW   = $clog2(HOP_WINDOW);
  localparam int EW   = KEY_W + DW;
  localparam int WMAX = (ADD_WINDOW > HOP_WINDOW) ? ADD_WINDOW : HOP_WINDOW;
  localparam int OW   = $clog2(WMAX + 1);
  localparam int SW   = ((AW > OW) ? AW : OW) + 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam logic [31:0] SLOTS32 = SLOTS;

  state_t             state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [AW-1:0]      home_r, home_nxt;
  logic [OW-1:0]      off_r, off_nxt;
  logic [OW-1:0]      chk_off_r, chk_off_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [OW-1:0]      pos_off_r, pos_off_nxt;
  logic [DW-1:0]      j_r, j_nxt;
  logic [DW-1:0]      chk_j_r, chk_j_nxt;
  logic [KEY_W-1:0]   mv_key_r, mv_key_nxt;
  logic [DW-1:0]      mv_dist_r, mv_dist_nxt;
  logic [DW-1:0]      mv_j_r, mv_j_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [POS_W-1:0]   out_position_r, out_position_nxt;
  logic [CNT_W-1:0]   out_count_r;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [EW-1:0]      wdata, rdata;
  logic [KEY_W-1:0]   rkey;
  logic [DW-1:0]      rdist;
  logic [SW-1:0]      scan_sum, chk_sum;
  logic [AW-1:0]      chk_pos;
  logic               scan_ok;
  logic [OW-1:0]      lim;
  logic [DW:0]        hop_sum;
  logic [31:0]        cnt_wide, pos_wide;

  // Slot store: key in the upper bits, distance from home in the lower bits.
  hkt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rkey  = rdata[EW-1:DW];
  assign rdist = rdata[DW-1:0];

  // Scan addressing relative to the home slot; the table does not wrap.
  assign scan_sum = SW'(home_r) + SW'(off_r);
  assign chk_sum  = SW'(home_r) + SW'(chk_off_r);
  assign chk_pos  = chk_sum[AW-1:0];
  assign lim      = (mode_r == MODE_INSERT) ? OW'(ADD_WINDOW) : OW'(HOP_WINDOW);
  assign scan_ok  = (off_r < lim) && (scan_sum < SW'(SLOTS));
  assign hop_sum  = (DW+1)'(rdist) + (DW+1)'(chk_j_r);

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r         <= mode_nxt;
    key_r          <= key_nxt;
    home_r         <= home_nxt;
    off_r          <= off_nxt;
    chk_off_r      <= chk_off_nxt;
    pos_r          <= pos_nxt;
    pos_off_r      <= pos_off_nxt;
    j_r            <= j_nxt;
    chk_j_r        <= chk_j_nxt;
    mv_key_r       <= mv_key_nxt;
    mv_dist_r      <= mv_dist_nxt;
    mv_j_r         <= mv_j_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_count_r    <= cnt_wide[CNT_W-1:0];
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    key_nxt          = key_r;
    home_nxt         = home_r;
    off_nxt          = off_r;
    chk_off_nxt      = chk_off_r;
    pend_nxt         = 1'b0;
    pos_nxt          = pos_r;
    pos_off_nxt      = pos_off_r;
    j_nxt            = j_r;
    chk_j_nxt        = chk_j_r;
    mv_key_nxt       = mv_key_r;
    mv_dist_nxt      = mv_dist_r;
    mv_j_nxt         = mv_j_r;
    cnt_nxt          = cnt_r;
    clr_nxt          = clr_r;
    out_strobe_nxt   = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    we               = 1'b0;
    waddr            = pos_r;
    wdata            = '0;
    raddr            = scan_sum[AW-1:0];
    pos_wide         = 32'(pos_r);

    unique case (state_r)
      ST_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key;
          home_nxt = in_key[AW-1:0];
          off_nxt  = '0;
          if (in_key == '0) begin
            out_strobe_nxt   = 1'b1;
            out_status_nxt   = STS_ZERO;
            out_position_nxt = SLOTS32[POS_W-1:0];
          end else if (in_mode != MODE_INSERT && in_mode != MODE_LOOKUP &&
                       in_mode != MODE_REMOVE) begin
            out_strobe_nxt   = 1'b1;
            out_status_nxt   = STS_NOT_FOUND;
            out_position_nxt = SLOTS32[POS_W-1:0];
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle and check the result of the read issued before it.
        pend_nxt    = scan_ok;
        chk_off_nxt = off_r;
        off_nxt     = off_r + 1'b1;
        pos_wide    = 32'(chk_pos);
        if (pend_r && mode_r == MODE_INSERT && rkey == '0) begin
          pos_nxt     = chk_pos;
          pos_off_nxt = chk_off_r;
          pend_nxt    = 1'b0;
          if (chk_off_r >= OW'(HOP_WINDOW)) begin
            j_nxt     = DW'(HOP_WINDOW - 1);
            state_nxt = ST_HOP;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (pend_r && rkey == key_r) begin
          out_strobe_nxt   = 1'b1;
          out_position_nxt = pos_wide[POS_W-1:0];
          state_nxt        = ST_IDLE;
          if (mode_r == MODE_INSERT) begin
            out_status_nxt = STS_PRESENT;
          end else begin
            out_status_nxt = STS_DONE;
            if (mode_r == MODE_REMOVE) begin
              we    = 1'b1;
              waddr = chk_pos;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
        end else if (!pend_r && !scan_ok) begin
          out_strobe_nxt   = 1'b1;
          out_position_nxt = SLOTS32[POS_W-1:0];
          out_status_nxt   = (mode_r == MODE_INSERT) ? STS_FULL : STS_NOT_FOUND;
          state_nxt        = ST_IDLE;
        end
      end

      ST_HOP: begin
        // Look for the earliest key below the free slot that may move into it.
        raddr     = pos_r - AW'(j_r);
        pend_nxt  = (j_r != '0);
        chk_j_nxt = j_r;
        if (j_r != '0) begin
          j_nxt = j_r - 1'b1;
        end
        if (pend_r && hop_sum <= (DW+1)'(HOP_WINDOW - 1)) begin
          mv_key_nxt  = rkey;
          mv_dist_nxt = hop_sum[DW-1:0];
          mv_j_nxt    = chk_j_r;
          pend_nxt    = 1'b0;
          state_nxt   = ST_MV1;
        end else if (!pend_r && j_r == '0) begin
          out_strobe_nxt   = 1'b1;
          out_status_nxt   = STS_FULL;
          out_position_nxt = SLOTS32[POS_W-1:0];
          state_nxt        = ST_IDLE;
        end
      end

      ST_MV1: begin
        we          = 1'b1;
        wdata       = {mv_key_r, mv_dist_r};
        pos_nxt     = pos_r - AW'(mv_j_r);
        pos_off_nxt = pos_off_r - OW'(mv_j_r);
        state_nxt   = ST_MV2;
      end

      ST_MV2: begin
        // The vacated slot becomes the new free slot.
        we = 1'b1;
        if (pos_off_r >= OW'(HOP_WINDOW)) begin
          j_nxt     = DW'(HOP_WINDOW - 1);
          state_nxt = ST_HOP;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        we               = 1'b1;
        wdata            = {key_r, pos_off_r[DW-1:0]};
        cnt_nxt          = cnt_r + 1'b1;
        out_strobe_nxt   = 1'b1;
        out_status_nxt   = STS_DONE;
        out_position_nxt = pos_wide[POS_W-1:0];
        state_nxt        = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cnt_wide = 32'(cnt_nxt);

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  // A result beat leaves the block ready for the next command.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // A zero key is answered in the next cycle.
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_key == '0) |=> (out_strobe && out_status == STS_ZERO))
    else $error("zero key not answered at once");

  // The stored count never exceeds the table size.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("entry count beyond table size");

  // The memory is never written while idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !we)
    else $error("slot write while idle");
`endif

endmodule
